FILE: design/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and constants of the per-warp register file cache: item
// layouts, operation and error codes, configuration indexes and counter types.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int MAX_WARPS_DEF = 64;
    localparam int MAX_LINES_DEF = 8;
    localparam int REG_BITS_DEF  = 8;

    localparam int LINES_W   = 4;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = 32;

    localparam logic [LINES_W-1:0] LINES_RESET = 4'd8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_EVICT  = 2'd2,
        OP_FREE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINES_IN_USE = 1'b0,
        CFG_REPLACE_MODE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        op_t        opcode;
        logic [5:0] warp;
        logic [7:0] reg_number;
        logic       mark_used;
        logic       count_read_hit;
        logic       count_write_hit;
    } in_item_t;

    typedef struct packed {
        logic             hit;
        logic [7:0]       evicted_reg;
        err_t             error_code;
        logic [3:0]       empty_lines;
        logic [CNT_W-1:0] inserts_total;
        logic [CNT_W-1:0] write_hits_total;
        logic [CNT_W-1:0] evicts_total;
        logic [CNT_W-1:0] read_hits_total;
    } out_item_t;

    typedef struct packed {
        logic insert;
        logic write_hit;
        logic evict;
        logic read_hit;
    } cnt_inc_t;

    typedef struct packed {
        logic [CNT_W-1:0] inserts;
        logic [CNT_W-1:0] write_hits;
        logic [CNT_W-1:0] evicts;
        logic [CNT_W-1:0] read_hits;
    } cnt_totals_t;

endpackage

FILE: design/rfc_row_mem.sv
// ----------------------------------------------------------------------------
// rfc_row_mem
// One row per warp holding the run length and the cached register numbers,
// with a valid flop per row so that reset and a flush empty every warp at once.
// ----------------------------------------------------------------------------
module rfc_row_mem #(
    parameter int MAX_WARPS = rfc_pkg::MAX_WARPS_DEF,
    parameter int MAX_LINES = rfc_pkg::MAX_LINES_DEF,
    parameter int REG_BITS  = rfc_pkg::REG_BITS_DEF,
    localparam int WARP_AW  = (MAX_WARPS > 1) ? $clog2(MAX_WARPS) : 1,
    localparam int LEN_W    = $clog2(MAX_LINES + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               clear_all,
    input  logic                               rd_en,
    input  logic [WARP_AW-1:0]                 rd_addr,
    output logic [MAX_LINES-1:0][REG_BITS-1:0] rd_slots,
    output logic [LEN_W-1:0]                   rd_len,
    input  logic                               wr_en,
    input  logic [WARP_AW-1:0]                 wr_addr,
    input  logic [MAX_LINES-1:0][REG_BITS-1:0] wr_slots,
    input  logic [LEN_W-1:0]                   wr_len
);

    localparam int ROW_W = LEN_W + MAX_LINES * REG_BITS;

    logic [ROW_W-1:0] mem [MAX_WARPS];
    logic [ROW_W-1:0] rd_row_reg;
    logic             row_vld_reg [MAX_WARPS];
    logic             rd_vld_reg;

    // row valid flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < MAX_WARPS; w++)
            begin
                row_vld_reg[w] <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                for (int w = 0; w < MAX_WARPS; w++)
                begin
                    row_vld_reg[w] <= 1'b0;
                end
            end
            else if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    // row storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_len, wr_slots};
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    assign rd_slots = rd_row_reg[MAX_LINES*REG_BITS-1:0];
    assign rd_len   = rd_vld_reg ? rd_row_reg[ROW_W-1:MAX_LINES*REG_BITS] : '0;

endmodule

FILE: design/rfc_counters.sv
// ----------------------------------------------------------------------------
// rfc_counters
// Four wrapping event counters for inserts, write hits, evictions and read
// hits, each stepped by one when its increment strobe is set.
// ----------------------------------------------------------------------------
module rfc_counters (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rfc_pkg::cnt_inc_t    inc,
    output rfc_pkg::cnt_totals_t totals
);

    rfc_pkg::cnt_totals_t cnt_reg;
    rfc_pkg::cnt_totals_t cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (inc.insert)
        begin
            cnt_next.inserts = cnt_reg.inserts + rfc_pkg::CNT_W'(1);
        end
        if (inc.write_hit)
        begin
            cnt_next.write_hits = cnt_reg.write_hits + rfc_pkg::CNT_W'(1);
        end
        if (inc.evict)
        begin
            cnt_next.evicts = cnt_reg.evicts + rfc_pkg::CNT_W'(1);
        end
        if (inc.read_hit)
        begin
            cnt_next.read_hits = cnt_reg.read_hits + rfc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign totals = cnt_reg;

endmodule

FILE: design/per_warp_register_file_cache_top.sv
// ----------------------------------------------------------------------------
// per_warp_register_file_cache_top
// An accepted item passes through a row read, a scan of the cached run by
// the single slot comparator (lookups of a non-empty run only), and a row
// write with the registered result; a stalled result channel holds it in
// the done state. No new item is taken until the last one is through.
// Reset empties every warp through the row valid flops and zeroes counters.
// ----------------------------------------------------------------------------
module per_warp_register_file_cache_top #(
    parameter int MAX_WARPS = rfc_pkg::MAX_WARPS_DEF,
    parameter int MAX_LINES = rfc_pkg::MAX_LINES_DEF,
    parameter int REG_BITS  = rfc_pkg::REG_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  rfc_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output rfc_pkg::out_item_t              out_item
);

    localparam int WARP_AW = (MAX_WARPS > 1) ? $clog2(MAX_WARPS) : 1;
    localparam int SLOT_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LEN_W   = $clog2(MAX_LINES + 1);

    typedef logic [MAX_LINES-1:0][REG_BITS-1:0] row_slots_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } state_t;

    // configuration
    logic [rfc_pkg::LINES_W-1:0] lines_reg;
    logic                        mode_reg;

    // sequencer and result
    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic                hit_reg, hit_next;
    logic                out_valid_reg, out_valid_next;
    logic                hit_o_reg, hit_o_next;
    logic [7:0]          evicted_o_reg, evicted_o_next;
    rfc_pkg::err_t       err_o_reg, err_o_next;
    logic [3:0]          empty_o_reg, empty_o_next;

    // item in flight
    rfc_pkg::op_t        op_reg;
    logic [WARP_AW-1:0]  warp_addr_reg;
    logic [REG_BITS-1:0] key_reg;
    logic                mark_reg;
    logic                cnt_rd_reg;
    logic                cnt_wr_reg;
    logic                in_range_reg;
    row_slots_t          slots_reg;
    logic [LEN_W-1:0]    len_reg;

    // row memory
    row_slots_t          rd_slots;
    logic [LEN_W-1:0]    rd_len;
    logic                clear_all;
    logic                wr_en;

    logic                accept;
    logic                out_free;
    logic                done_fire;
    logic [LEN_W-1:0]    n_act;
    logic                match;
    logic                idx_last;
    logic                ins_ok;
    logic                ev_ok;
    logic                lru_mv;
    logic                do_shift;
    logic [SLOT_W-1:0]   shift_from;
    row_slots_t          slots_up;
    row_slots_t          new_slots;
    logic [LEN_W-1:0]    new_len;
    rfc_pkg::err_t       err_val;

    rfc_pkg::cnt_inc_t    cnt_inc;
    rfc_pkg::cnt_totals_t totals;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign done_fire = (state_reg == S_DONE) && out_free;
    assign clear_all = cfg_we && (cfg_index == rfc_pkg::CFG_LINES_IN_USE);
    assign wr_en     = done_fire && in_range_reg;

    assign n_act = (32'(lines_reg) > MAX_LINES) ? LEN_W'(MAX_LINES) : LEN_W'(lines_reg);

    // shared slot comparator
    assign match    = (slots_reg[idx_reg] == key_reg);
    assign idx_last = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);

    // row update
    assign ins_ok   = in_range_reg && (op_reg == rfc_pkg::OP_INSERT) && (len_reg < n_act);
    assign ev_ok    = in_range_reg && (op_reg == rfc_pkg::OP_EVICT) && (len_reg != '0);
    assign lru_mv   = (op_reg == rfc_pkg::OP_LOOKUP) && hit_reg && mark_reg && mode_reg;
    assign do_shift = ev_ok || lru_mv;
    assign shift_from = ev_ok ? '0 : idx_reg;
    assign slots_up = slots_reg >> REG_BITS;

    always_comb
    begin
        for (int j = 0; j < MAX_LINES; j++)
        begin
            new_slots[j] = slots_reg[j];
            if (do_shift && (j >= int'(shift_from)) && (j + 1 < int'(len_reg)))
            begin
                new_slots[j] = slots_up[j];
            end
            if ((lru_mv && (j + 1 == int'(len_reg))) || (ins_ok && (j == int'(len_reg))))
            begin
                new_slots[j] = key_reg;
            end
        end
    end

    always_comb
    begin
        new_len = len_reg;
        err_val = rfc_pkg::ERR_NONE;
        case (op_reg)
            rfc_pkg::OP_INSERT:
            begin
                if (ins_ok)
                begin
                    new_len = len_reg + LEN_W'(1);
                end
                else
                begin
                    err_val = rfc_pkg::ERR_FULL;
                end
            end
            rfc_pkg::OP_EVICT:
            begin
                if (ev_ok)
                begin
                    new_len = len_reg - LEN_W'(1);
                end
                else
                begin
                    err_val = rfc_pkg::ERR_EMPTY;
                end
            end
            rfc_pkg::OP_FREE:
            begin
                new_len = '0;
            end
            default:
            begin
                new_len = len_reg;
            end
        endcase
    end

    always_comb
    begin
        cnt_inc.insert    = done_fire && ins_ok;
        cnt_inc.evict     = done_fire && ev_ok;
        cnt_inc.read_hit  = done_fire && hit_reg && cnt_rd_reg;
        cnt_inc.write_hit = done_fire && hit_reg && cnt_wr_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && out_stall;
        hit_o_next     = hit_o_reg;
        evicted_o_next = evicted_o_reg;
        err_o_next     = err_o_reg;
        empty_o_next   = empty_o_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                end
            end
            S_READ:
            begin
                if (in_range_reg && (op_reg == rfc_pkg::OP_LOOKUP) && (rd_len != '0))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    hit_o_next     = hit_reg;
                    evicted_o_next = ev_ok ? 8'(slots_reg[0]) : 8'd0;
                    err_o_next     = in_range_reg ? err_val : rfc_pkg::ERR_NONE;
                    empty_o_next   = in_range_reg ? 4'(n_act - new_len) : 4'd0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_o_reg     <= 1'b0;
            evicted_o_reg <= '0;
            err_o_reg     <= rfc_pkg::ERR_NONE;
            empty_o_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            hit_o_reg     <= hit_o_next;
            evicted_o_reg <= evicted_o_next;
            err_o_reg     <= err_o_next;
            empty_o_reg   <= empty_o_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_reg <= rfc_pkg::LINES_RESET;
            mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rfc_pkg::CFG_LINES_IN_USE)
            begin
                lines_reg <= cfg_data;
            end
            else
            begin
                mode_reg <= cfg_data[0];
            end
        end
    end

    // item capture and row load
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= in_item.opcode;
            warp_addr_reg <= WARP_AW'(in_item.warp);
            key_reg       <= REG_BITS'(in_item.reg_number);
            mark_reg      <= in_item.mark_used;
            cnt_rd_reg    <= in_item.count_read_hit;
            cnt_wr_reg    <= in_item.count_write_hit;
            in_range_reg  <= (32'(in_item.warp) < MAX_WARPS);
        end
        if (state_reg == S_READ)
        begin
            slots_reg <= rd_slots;
            len_reg   <= rd_len;
        end
    end

    rfc_row_mem #(
        .MAX_WARPS (MAX_WARPS),
        .MAX_LINES (MAX_LINES),
        .REG_BITS  (REG_BITS)
    ) u_row_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (clear_all),
        .rd_en     (accept),
        .rd_addr   (WARP_AW'(in_item.warp)),
        .rd_slots  (rd_slots),
        .rd_len    (rd_len),
        .wr_en     (wr_en),
        .wr_addr   (warp_addr_reg),
        .wr_slots  (new_slots),
        .wr_len    (new_len)
    );

    rfc_counters u_counters (
        .clk    (clk),
        .rst_n  (rst_n),
        .inc    (cnt_inc),
        .totals (totals)
    );

    assign out_valid                 = out_valid_reg;
    assign out_item.hit              = hit_o_reg;
    assign out_item.evicted_reg      = evicted_o_reg;
    assign out_item.error_code       = err_o_reg;
    assign out_item.empty_lines      = empty_o_reg;
    assign out_item.inserts_total    = totals.inserts;
    assign out_item.write_hits_total = totals.write_hits;
    assign out_item.evicts_total     = totals.evicts;
    assign out_item.read_hits_total  = totals.read_hits;

endmodule

FILE: design/rfc_checker.sv
// ----------------------------------------------------------------------------
// rfc_checker
// Port-level checks on the register file cache: result channel holding,
// busy after an accepted item, and consistency of the result fields.
// ----------------------------------------------------------------------------
module rfc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input rfc_pkg::out_item_t out_item
);

    // stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result item dropped or changed");

    // busy after an item is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("new item accepted straight after another");

    // a hit carries no error and no eviction
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.hit |->
            out_item.error_code == rfc_pkg::ERR_NONE && out_item.evicted_reg == 8'd0)
        else $error("hit reported with error or evicted register");

    // insert and evict counters only move with a new result
    a_cnt_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(out_item.inserts_total) || !$stable(out_item.evicts_total) |-> out_valid)
        else $error("counter changed without a result item");

    // an error result flags no hit
    a_evict_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.error_code != rfc_pkg::ERR_NONE |-> !out_item.hit)
        else $error("error result also flags a hit");

endmodule

bind per_warp_register_file_cache_top rfc_checker u_rfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

FILE: bench/rfc_result_check.sv
// ----------------------------------------------------------------------------
// rfc_result_check
// Watches the configuration port and both item channels of the per-warp
// register file cache. It keeps its own copy of every warp's cached run and
// of the event counters. For each accepted input item it works out the
// result that is due. Each accepted result is compared, field by field, with
// the oldest result still due. It reports how many fields disagreed and how
// many results are still owed.
// ----------------------------------------------------------------------------
module rfc_result_check #(
    parameter int MAX_WARPS = rfc_pkg::MAX_WARPS_DEF,
    parameter int MAX_LINES = rfc_pkg::MAX_LINES_DEF,
    parameter int REG_BITS  = rfc_pkg::REG_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  rfc_pkg::in_item_t               in_item,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  rfc_pkg::out_item_t              out_item,
    output int                              mismatches,
    output int                              outstanding
);

    import rfc_pkg::*;

    logic [REG_BITS-1:0]  line_reg [MAX_WARPS][MAX_LINES];
    int                   run_len [MAX_WARPS];
    logic [LINES_W-1:0]   lines_cfg;
    logic                 lru_mode;
    logic [CNT_W-1:0]     inserts_seen;
    logic [CNT_W-1:0]     write_hits_seen;
    logic [CNT_W-1:0]     evicts_seen;
    logic [CNT_W-1:0]     read_hits_seen;
    out_item_t            awaited_results [$];
    int                   results_seen;

    function automatic out_item_t cache_op_result(in_item_t it);
        out_item_t           res;
        int                  n;
        int                  w;
        int                  len;
        int                  pos;
        int                  i;
        logic [REG_BITS-1:0] r;
        res = '0;
        n = (lines_cfg > MAX_LINES) ? MAX_LINES : int'(lines_cfg);
        w = int'(it.warp);
        r = it.reg_number[REG_BITS-1:0];
        if (w < MAX_WARPS)
        begin
            len = run_len[w];
            case (it.opcode)
                OP_INSERT:
                begin
                    if (len < n)
                    begin
                        line_reg[w][len] = r;
                        len = len + 1;
                        inserts_seen = inserts_seen + 1;
                    end
                    else
                    begin
                        res.error_code = ERR_FULL;
                    end
                end
                OP_LOOKUP:
                begin
                    pos = -1;
                    for (i = 0; i < len; i++)
                    begin
                        if (pos < 0 && line_reg[w][i] == r)
                            pos = i;
                    end
                    if (pos >= 0)
                    begin
                        res.hit = 1'b1;
                        if (it.count_read_hit)
                            read_hits_seen = read_hits_seen + 1;
                        if (it.count_write_hit)
                            write_hits_seen = write_hits_seen + 1;
                        // a marked hit moves to the newest end under lru
                        if (it.mark_used && lru_mode)
                        begin
                            for (i = pos; i + 1 < len; i++)
                                line_reg[w][i] = line_reg[w][i + 1];
                            line_reg[w][len - 1] = r;
                        end
                    end
                end
                OP_EVICT:
                begin
                    if (len > 0)
                    begin
                        res.evicted_reg = line_reg[w][0];
                        for (i = 0; i + 1 < len; i++)
                            line_reg[w][i] = line_reg[w][i + 1];
                        len = len - 1;
                        evicts_seen = evicts_seen + 1;
                    end
                    else
                    begin
                        res.error_code = ERR_EMPTY;
                    end
                end
                default:
                begin
                    len = 0;
                end
            endcase
            run_len[w] = len;
            res.empty_lines = 4'(n - len);
        end
        res.inserts_total    = inserts_seen;
        res.write_hits_total = write_hits_seen;
        res.evicts_total     = evicts_seen;
        res.read_hits_total  = read_hits_seen;
        return res;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: result %0d %s expected 0x%0h, got 0x%0h",
                     $time, results_seen, what, want, got);
            mismatches = mismatches + 1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        int        w;
        if (!rst_n)
        begin
            lines_cfg       = LINES_RESET;
            lru_mode        = 1'b0;
            inserts_seen    = '0;
            write_hits_seen = '0;
            evicts_seen     = '0;
            read_hits_seen  = '0;
            for (w = 0; w < MAX_WARPS; w++)
                run_len[w] = 0;
            awaited_results.delete();
            results_seen = 0;
            mismatches   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_LINES_IN_USE)
                begin
                    lines_cfg = cfg_data;
                    for (w = 0; w < MAX_WARPS; w++)
                        run_len[w] = 0;
                end
                else
                begin
                    lru_mode = cfg_data[0];
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(cache_op_result(in_item));
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result %0d expected none, got 0x%0h",
                             $time, results_seen, out_item);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(out_item.hit));
                    check_field("evicted_reg", 32'(want.evicted_reg),
                                32'(out_item.evicted_reg));
                    check_field("error_code", 32'(want.error_code),
                                32'(out_item.error_code));
                    check_field("empty_lines", 32'(want.empty_lines),
                                32'(out_item.empty_lines));
                    check_field("inserts_total", want.inserts_total,
                                out_item.inserts_total);
                    check_field("write_hits_total", want.write_hits_total,
                                out_item.write_hits_total);
                    check_field("evicts_total", want.evicts_total, out_item.evicts_total);
                    check_field("read_hits_total", want.read_hits_total,
                                out_item.read_hits_total);
                end
                results_seen = results_seen + 1;
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

FILE: bench/per_warp_register_file_cache_top_test.sv
// ----------------------------------------------------------------------------
// per_warp_register_file_cache_top_test
// Drives the register file cache with a short directed run over empty, full
// and disabled caches, duplicates, FIFO and LRU hits, then with random
// operations focused on a few warps and a small register pool, across
// several line counts and both replacement modes, with random idling on
// both channels. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module per_warp_register_file_cache_top_test;

    import rfc_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_TICKS = 24;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_item;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_item;
    int                     mismatches;
    int                     outstanding;
    int                     send_idle;
    int                     recv_idle;
    int                     quiet_cycles;

    per_warp_register_file_cache_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    rfc_result_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic in_item_t make_item(op_t op, logic [5:0] warp, logic [7:0] r,
                                           logic mark, logic cnt_rd, logic cnt_wr);
        in_item_t it;
        it.opcode          = op;
        it.warp            = warp;
        it.reg_number      = r;
        it.mark_used       = mark;
        it.count_read_hit  = cnt_rd;
        it.count_write_hit = cnt_wr;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] lines, input logic lru,
                             input int s_idle, input int r_idle, input int count);
        in_item_t it;
        int       p;
        write_reg(CFG_LINES_IN_USE, lines);
        write_reg(CFG_REPLACE_MODE, {{(CFG_W-1){1'b0}}, lru});
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (count)
        begin
            p = $urandom_range(99);
            if (p < 40)
                it.opcode = OP_INSERT;
            else if (p < 75)
                it.opcode = OP_LOOKUP;
            else if (p < 92)
                it.opcode = OP_EVICT;
            else
                it.opcode = OP_FREE;
            // a few busy warps and a small register pool, so runs fill and hit
            if ($urandom_range(99) < 80)
                it.warp = 6'($urandom_range(3));
            else
                it.warp = 6'($urandom_range(63));
            if ($urandom_range(99) < 70)
                it.reg_number = 8'($urandom_range(7));
            else
                it.reg_number = 8'($urandom_range(255));
            it.mark_used       = 1'($urandom_range(1));
            it.count_read_hit  = 1'($urandom_range(1));
            it.count_write_hit = 1'($urandom_range(1));
            send_item(it);
            if ($urandom_range(99) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_LINES_IN_USE;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_item      = '0;
        send_idle    = 19;
        recv_idle    = 88;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // eight lines, fifo order
        send_item(make_item(OP_EVICT,  6'd0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOOKUP, 6'd0, 8'h05, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_INSERT, 6'd0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_INSERT, 6'd0, 8'hFF, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_INSERT, 6'd0, 8'h5A, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_INSERT, 6'd0, 8'hA5, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_INSERT, 6'd0, 8'h01, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_INSERT, 6'd0, 8'h80, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_INSERT, 6'd0, 8'hFF, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_INSERT, 6'd0, 8'h7F, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_INSERT, 6'd0, 8'h33, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOOKUP, 6'd0, 8'hFF, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_EVICT,  6'd0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_INSERT, 6'd63, 8'hC3, 1'b0, 1'b0, 1'b0));

        // lru: a marked hit in mid run moves to the newest end
        write_reg(CFG_REPLACE_MODE, 4'd1);
        send_item(make_item(OP_LOOKUP, 6'd0, 8'h5A, 1'b1, 1'b1, 1'b0));
        send_item(make_item(OP_EVICT,  6'd0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOOKUP, 6'd0, 8'h7F, 1'b0, 1'b0, 1'b1));
        send_item(make_item(OP_FREE,   6'd0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOOKUP, 6'd0, 8'hFF, 1'b1, 1'b1, 1'b1));

        // cache disabled
        write_reg(CFG_LINES_IN_USE, 4'd0);
        send_item(make_item(OP_INSERT, 6'd0, 8'h12, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOOKUP, 6'd0, 8'h12, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_EVICT,  6'd0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_FREE,   6'd63, 8'h00, 1'b0, 1'b0, 1'b0));

        run_phase(4'd15, 1'b0, 19, 88, 260);
        run_phase(4'd1,  1'b1, 19, 88, 260);
        run_phase(4'd3,  1'b0, 88, 19, 260);
        run_phase(4'd8,  1'b1, 88, 19, 300);
        run_phase(4'd5,  1'b1, 0, 0, 300);
        run_phase(4'd2,  1'b0, 0, 0, 300);

        drain_results();
        repeat (SETTLE_TICKS) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
